// ===== design/pl0sm_pkg.sv =====
// Shared types, codes and constants for the PL/0 stack machine step block.
// No dependencies; imported by the step module, the checker and the testbench.
package pl0sm_pkg;

  localparam int STACK_DEPTH    = 4096;
  localparam int STACK_AW       = $clog2(STACK_DEPTH);
  localparam int CODE_DEPTH     = 1024;
  localparam int PC_W           = $clog2(CODE_DEPTH);
  localparam int MAX_CALL_DEPTH = 32;
  localparam int PTR_W          = 13;
  localparam int FD_W           = 6;
  localparam int WORD_W         = 32;
  localparam int LVL_W          = 5;
  localparam int CALC_W         = 35;
  localparam int CFG_IDX_W      = 2;

  typedef logic [STACK_AW-1:0] saddr_t;
  typedef logic [WORD_W-1:0]   word_t;

  typedef enum logic [3:0] {
    OP_DEC = 4'd0, OP_LIT = 4'd1, OP_OPR = 4'd2, OP_LOD = 4'd3,
    OP_STO = 4'd4, OP_CAL = 4'd5, OP_INC = 4'd6, OP_JMP = 4'd7,
    OP_JPC = 4'd8, OP_SIO = 4'd9, OP_LDA = 4'd10, OP_STA = 4'd11
  } opcode_t;

  typedef enum logic [3:0] {
    ST_OK = 4'd0, ST_UNDER = 4'd1, ST_OVER = 4'd2, ST_DEPTH = 4'd3,
    ST_DIVZ = 4'd4, ST_BADOPR = 4'd5, ST_BADIO = 4'd6, ST_BOUNDS = 4'd7,
    ST_PCRANGE = 4'd8, ST_MAINRET = 4'd9
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WALK, S_WALK_DATA, S_RD1, S_RD2, S_RD3,
    S_EXEC, S_DIV, S_COMPUTE, S_WRITE, S_FIN
  } state_t;

  // OPR sub-operations
  localparam int OPR_RET = 0;
  localparam int OPR_NEG = 1;
  localparam int OPR_ADD = 2;
  localparam int OPR_SUB = 3;
  localparam int OPR_MUL = 4;
  localparam int OPR_DIV = 5;
  localparam int OPR_ODD = 6;
  localparam int OPR_MOD = 7;
  localparam int OPR_EQ  = 8;
  localparam int OPR_NE  = 9;
  localparam int OPR_LT  = 10;
  localparam int OPR_LE  = 11;
  localparam int OPR_GT  = 12;
  localparam int OPR_GE  = 13;

  // SIO sub-operations
  localparam int SIO_OUT0 = 0;
  localparam int SIO_OUT1 = 1;
  localparam int SIO_IN   = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ENABLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STACK_LIMIT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CALL_DEPTH_LIMIT = 2'd2;

  // stack pointer candidate check: underflow, overflow or fine
  function automatic status_t sp_check(input logic signed [CALC_W-1:0] c,
                                       input logic ce,
                                       input logic [PTR_W-1:0] lim);
    status_t r;
    r = ST_OK;
    if (ce) begin
      if (c < 0) r = ST_UNDER;
      else if (c >= $signed({{(CALC_W-PTR_W){1'b0}}, lim}) ||
               c >= $signed(CALC_W'(STACK_DEPTH))) r = ST_OVER;
    end
    return r;
  endfunction

endpackage

// ===== design/pl0sm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pl0sm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== design/pl0_stack_machine_step.sv =====
// PL/0 stack machine, one instruction per input transfer.
// Depends on pl0sm_pkg and pl0sm_ram (stack memory).
//
//  channel   | handshake            | payload
//  ----------+----------------------+--------------------------------------------
//  input     | in_valid / in_ready  | opcode, level, modifier, read_value
//  result    | res_valid / res_ready| next_pc, out_valid, out_value, halted, status
//  config    | cfg_we (no wait)     | cfg_index, cfg_data
//
// Sequence per instruction from one input transfer to the next: link probe
// and static link walk for LOD/STO/CAL/LDA/STA (a probe and a data step per
// level), three stack reads, execute, the radix-2 divider for div/mod,
// compute, any stack writes (three frame words for CAL), result.
// The single stack read port sets the read sequence. A halted machine goes
// from idle straight to compute and result. After reset a clearing pass
// writes all 4096 stack words with in_ready low. A stalled result does not
// block the next input transfer; the next result waits in the final state.
module pl0_stack_machine_step (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [3:0]                          opcode,
  input  logic [pl0sm_pkg::LVL_W-1:0]         level,
  input  logic signed [pl0sm_pkg::WORD_W-1:0] modifier,
  input  logic signed [pl0sm_pkg::WORD_W-1:0] read_value,
  output logic                                res_valid,
  input  logic                                res_ready,
  output logic [pl0sm_pkg::PC_W-1:0]          next_pc,
  output logic                                out_valid,
  output logic signed [pl0sm_pkg::WORD_W-1:0] out_value,
  output logic                                halted,
  output logic [3:0]                          status,
  input  logic                                cfg_we,
  input  logic [pl0sm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pl0sm_pkg::PTR_W-1:0]         cfg_data
);
  import pl0sm_pkg::*;

  state_t state, state_next;

  // architectural state
  logic [PTR_W-1:0] sp, bp;
  logic [PC_W-1:0]  pc;
  logic [FD_W-1:0]  fd;
  logic             halt_flag;
  status_t          halt_cause;
  logic             check_enable;
  logic [PTR_W-1:0] stack_limit;
  logic [FD_W-1:0]  call_depth_limit;

  // per-instruction working registers
  opcode_t            op;
  logic [LVL_W-1:0]   lvl_cnt;
  logic signed [31:0] m_reg;
  word_t              rv_reg, fb, t1, t2, t3;
  saddr_t             clr_cnt;
  word_t              dv_rem, dv_quo, dv_dvs;
  logic [4:0]         dv_cnt;
  logic [1:0]         w_num, w_idx;
  saddr_t             wa [3];
  word_t              wd [3];
  logic               p_ov_v;
  word_t              p_ov;
  status_t            p_status;

  // stack memory port
  logic   ram_we;
  saddr_t ram_waddr, ram_raddr;
  word_t  ram_wdata, ram_rdata;

  pl0sm_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // common operands
  logic signed [CALC_W-1:0] s35, b35, m35;
  logic signed [31:0]       pc_inc;
  saddr_t                   s12, b12, fbm;
  logic                     is_ret, is_binop, is_div;

  assign s35    = $signed({{(CALC_W-PTR_W){1'b0}}, sp});
  assign b35    = $signed({{(CALC_W-PTR_W){1'b0}}, bp});
  assign m35    = $signed({{(CALC_W-32){m_reg[31]}}, m_reg});
  assign pc_inc = $signed({{(32-PC_W){1'b0}}, pc} + 32'd1);
  assign s12    = sp[STACK_AW-1:0];
  assign b12    = bp[STACK_AW-1:0];
  assign fbm    = fb[STACK_AW-1:0] + m_reg[STACK_AW-1:0];
  assign is_ret   = (op == OP_OPR) && (m_reg == OPR_RET);
  assign is_binop = (op == OP_OPR) && (m_reg >= OPR_ADD) && (m_reg <= OPR_GE) &&
                    (m_reg != OPR_ODD);
  assign is_div   = (op == OP_OPR) && ((m_reg == OPR_DIV) || (m_reg == OPR_MOD)) &&
                    (t2 != '0);

  // read addresses of the three operand fetches
  saddr_t addr1, addr2, addr3;
  always_comb begin
    addr1 = s12;
    addr2 = s12;
    addr3 = s12;
    case (op)
      OP_OPR: begin
        if (is_ret) begin
          addr1 = (fd == '0) ? STACK_AW'(1) : b12 + STACK_AW'(3);
          addr2 = b12 + STACK_AW'(2);
        end else if (is_binop) begin
          addr1 = s12 - STACK_AW'(1);
        end
      end
      OP_LOD: addr1 = fbm;
      OP_LDA: begin
        addr2 = fbm;
        addr3 = fbm + t1[STACK_AW-1:0] + STACK_AW'(1);
      end
      OP_STA: begin
        addr1 = s12 - STACK_AW'(1);
        addr2 = fbm;
      end
      default: addr1 = s12;
    endcase
  end

  // divider step
  logic [32:0] dv_sh, dv_diff;
  assign dv_sh   = {dv_rem, dv_quo[31]};
  assign dv_diff = dv_sh - {1'b0, dv_dvs};

  // execute: status, pointer updates, result and memory writes
  status_t                  c_pre, c_fin;
  logic signed [CALC_W-1:0] c_cand, c_ns;
  logic [PTR_W-1:0]         c_nb, c_ns13;
  logic signed [31:0]       c_npc;
  logic [FD_W-1:0]          c_nfd;
  logic                     c_ov_v;
  word_t                    c_ov, c_bin, q_s, r_s;
  logic [1:0]               c_wn;
  saddr_t                   c_wa [3];
  word_t                    c_wd [3];

  assign q_s = (t1[31] ^ t2[31]) ? (32'd0 - dv_quo) : dv_quo;
  assign r_s = t1[31] ? (32'd0 - dv_rem) : dv_rem;

  always_comb begin
    c_pre  = ST_OK;
    c_cand = s35;
    c_ns   = s35;
    c_nb   = bp;
    c_npc  = pc_inc;
    c_nfd  = fd;
    c_ov_v = 1'b0;
    c_ov   = '0;
    c_bin  = '0;
    c_wn   = 2'd0;
    for (int i = 0; i < 3; i++) begin
      c_wa[i] = s12;
      c_wd[i] = '0;
    end
    case (op)
      OP_DEC, OP_INC: begin
        c_cand = (op == OP_DEC) ? s35 - m35 : s35 + m35;
        c_pre  = sp_check(c_cand, check_enable, stack_limit);
        c_ns   = c_cand;
      end
      OP_LIT, OP_LOD: begin
        c_cand  = s35 + 35'sd1;
        c_pre   = sp_check(c_cand, check_enable, stack_limit);
        c_ns    = c_cand;
        c_wn    = 2'd1;
        c_wa[0] = s12 + STACK_AW'(1);
        c_wd[0] = (op == OP_LIT) ? m_reg : t1;
      end
      OP_OPR: begin
        if (is_ret) begin
          if (fd == '0) begin
            c_ov_v = 1'b1;
            c_ov   = t1;
            c_pre  = ST_MAINRET;
          end else begin
            c_cand = b35 - 35'sd1;
            c_pre  = sp_check(c_cand, check_enable, stack_limit);
            c_ns   = c_cand;
            c_npc  = $signed(t1);
            c_nb   = t2[PTR_W-1:0];
            c_nfd  = fd - FD_W'(1);
          end
        end else if (m_reg == OPR_NEG) begin
          c_wn    = 2'd1;
          c_wd[0] = 32'd0 - t1;
        end else if (m_reg == OPR_ODD) begin
          c_wn    = 2'd1;
          c_wd[0] = {31'd0, t1[0]};
        end else if (is_binop) begin
          c_cand = s35 - 35'sd1;
          c_pre  = sp_check(c_cand, check_enable, stack_limit);
          c_ns   = c_cand;
          case (m_reg)
            OPR_ADD: c_bin = t1 + t2;
            OPR_SUB: c_bin = t1 - t2;
            OPR_MUL: c_bin = t1 * t2;
            OPR_DIV: c_bin = q_s;
            OPR_MOD: c_bin = r_s;
            OPR_EQ:  c_bin = {31'd0, t1 == t2};
            OPR_NE:  c_bin = {31'd0, t1 != t2};
            OPR_LT:  c_bin = {31'd0, $signed(t1) <  $signed(t2)};
            OPR_LE:  c_bin = {31'd0, $signed(t1) <= $signed(t2)};
            OPR_GT:  c_bin = {31'd0, $signed(t1) >  $signed(t2)};
            default: c_bin = {31'd0, $signed(t1) >= $signed(t2)};
          endcase
          if (c_pre == ST_OK && (m_reg == OPR_DIV || m_reg == OPR_MOD) && t2 == '0)
            c_pre = ST_DIVZ;
          c_wn    = 2'd1;
          c_wa[0] = s12 - STACK_AW'(1);
          c_wd[0] = c_bin;
        end else begin
          c_pre = ST_BADOPR;
        end
      end
      OP_STO: begin
        c_cand  = s35 - 35'sd1;
        c_pre   = sp_check(c_cand, check_enable, stack_limit);
        c_ns    = c_cand;
        c_wn    = 2'd1;
        c_wa[0] = fbm;
        c_wd[0] = t1;
      end
      OP_CAL: begin
        if (fd >= call_depth_limit || fd >= FD_W'(MAX_CALL_DEPTH)) begin
          c_pre = ST_DEPTH;
        end else begin
          c_pre   = sp_check(s35 + 35'sd4, check_enable, stack_limit);
          c_wn    = 2'd3;
          c_wa[0] = s12 + STACK_AW'(2);
          c_wd[0] = fb;
          c_wa[1] = s12 + STACK_AW'(3);
          c_wd[1] = {{(32-PTR_W){1'b0}}, bp};
          c_wa[2] = s12 + STACK_AW'(4);
          c_wd[2] = pc_inc;
          c_nb    = sp + PTR_W'(1);
          c_npc   = m_reg;
          c_nfd   = fd + FD_W'(1);
        end
      end
      OP_JMP: c_npc = m_reg;
      OP_JPC: begin
        c_cand = s35 - 35'sd1;
        c_pre  = sp_check(c_cand, check_enable, stack_limit);
        c_ns   = c_cand;
        if (t1 == '0) c_npc = m_reg;
      end
      OP_SIO: begin
        if (m_reg == SIO_IN) begin
          c_cand  = s35 + 35'sd1;
          c_pre   = sp_check(c_cand, check_enable, stack_limit);
          c_ns    = c_cand;
          c_wn    = 2'd1;
          c_wa[0] = s12 + STACK_AW'(1);
          c_wd[0] = rv_reg;
        end else if (m_reg == SIO_OUT0 || m_reg == SIO_OUT1) begin
          c_cand = s35 - 35'sd1;
          c_pre  = sp_check(c_cand, check_enable, stack_limit);
          c_ns   = c_cand;
          c_ov_v = 1'b1;
          c_ov   = t1;
        end else begin
          c_pre = ST_BADIO;
        end
      end
      OP_LDA: begin
        c_pre = sp_check(s35, check_enable, stack_limit);
        if (c_pre == ST_OK && ($signed(t1) < 0 || $signed(t1) >= $signed(t2)))
          c_pre = ST_BOUNDS;
        c_wn    = 2'd1;
        c_wd[0] = t3;
      end
      OP_STA: begin
        c_cand = s35 - 35'sd2;
        c_pre  = sp_check(c_cand, check_enable, stack_limit);
        if (c_pre == ST_OK && ($signed(t1) < 0 || $signed(t1) >= $signed(t2)))
          c_pre = ST_BOUNDS;
        c_ns    = c_cand;
        c_wn    = 2'd1;
        c_wa[0] = fbm + t1[STACK_AW-1:0] + STACK_AW'(1);
        c_wd[0] = t3;
      end
      default: c_pre = ST_BADOPR;
    endcase

    // a failing instruction only advances the pc
    if (c_pre != ST_OK && c_pre != ST_MAINRET) begin
      c_ov_v = 1'b0;
      c_ov   = '0;
      c_npc  = pc_inc;
      c_ns   = s35;
      c_nb   = bp;
      c_nfd  = fd;
      c_wn   = 2'd0;
    end
    c_ns13 = c_ns[PTR_W-1:0];

    // range checks on the updated state
    c_fin = c_pre;
    if (c_pre == ST_OK && check_enable) begin
      if (c_ns13 >= stack_limit || c_ns13 >= PTR_W'(STACK_DEPTH)) c_fin = ST_OVER;
      else if (c_npc < 0 || c_npc >= $signed(32'(CODE_DEPTH))) c_fin = ST_PCRANGE;
    end
  end

  // sequencer: next state and memory port
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = clr_cnt;
    ram_wdata  = '0;
    ram_raddr  = s12;
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (clr_cnt == STACK_AW'(STACK_DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = halt_flag ? S_COMPUTE : S_WALK;
      end
      S_WALK: begin
        ram_raddr  = fb[STACK_AW-1:0] + STACK_AW'(1);
        state_next = (lvl_cnt == '0) ? S_RD1 : S_WALK_DATA;
      end
      S_WALK_DATA: state_next = S_WALK;
      S_RD1: begin
        ram_raddr  = addr1;
        state_next = S_RD2;
      end
      S_RD2: begin
        ram_raddr  = addr2;
        state_next = S_RD3;
      end
      S_RD3: begin
        ram_raddr  = addr3;
        state_next = S_EXEC;
      end
      S_EXEC: state_next = is_div ? S_DIV : S_COMPUTE;
      S_DIV: begin
        if (dv_cnt == '0) state_next = S_COMPUTE;
      end
      S_COMPUTE: state_next = (!halt_flag && c_wn != 2'd0) ? S_WRITE : S_FIN;
      S_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = wa[w_idx];
        ram_wdata = wd[w_idx];
        if (w_idx == w_num - 2'd1) state_next = S_FIN;
      end
      S_FIN: begin
        if (!res_valid || res_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready = (state == S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  // datapath and architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt          <= '0;
      sp               <= '0;
      bp               <= PTR_W'(1);
      pc               <= '0;
      fd               <= '0;
      halt_flag        <= 1'b0;
      halt_cause       <= ST_OK;
      check_enable     <= 1'b1;
      stack_limit      <= PTR_W'(STACK_DEPTH);
      call_depth_limit <= FD_W'(MAX_CALL_DEPTH);
      res_valid        <= 1'b0;
      w_idx            <= '0;
      dv_cnt           <= '0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_CHECK_ENABLE:     check_enable     <= cfg_data[0];
          CFG_STACK_LIMIT:      stack_limit      <= cfg_data;
          CFG_CALL_DEPTH_LIMIT: call_depth_limit <= cfg_data[FD_W-1:0];
          default: ;
        endcase
      end

      // result transfer; the final state loads the next result itself
      if (res_valid && res_ready && state != S_FIN) res_valid <= 1'b0;

      case (state)
        S_CLEAR: clr_cnt <= clr_cnt + STACK_AW'(1);
        S_IDLE: begin
          if (in_valid) begin
            op      <= opcode_t'(opcode);
            m_reg   <= modifier;
            rv_reg  <= read_value;
            fb      <= {{(32-PTR_W){1'b0}}, bp};
            // only frame-relative instructions walk static links
            if (opcode_t'(opcode) == OP_LOD || opcode_t'(opcode) == OP_STO ||
                opcode_t'(opcode) == OP_CAL || opcode_t'(opcode) == OP_LDA ||
                opcode_t'(opcode) == OP_STA)
              lvl_cnt <= level;
            else
              lvl_cnt <= '0;
          end
        end
        S_WALK_DATA: begin
          fb      <= ram_rdata;
          lvl_cnt <= lvl_cnt - LVL_W'(1);
        end
        S_RD2: t1 <= ram_rdata;
        S_RD3: t2 <= ram_rdata;
        S_EXEC: begin
          t3     <= ram_rdata;
          dv_quo <= t1[31] ? (32'd0 - t1) : t1;
          dv_dvs <= t2[31] ? (32'd0 - t2) : t2;
          dv_rem <= '0;
          dv_cnt <= 5'd31;
        end
        S_DIV: begin
          // one restoring step per cycle
          if (!dv_diff[32]) begin
            dv_rem <= dv_diff[31:0];
            dv_quo <= {dv_quo[30:0], 1'b1};
          end else begin
            dv_rem <= dv_sh[31:0];
            dv_quo <= {dv_quo[30:0], 1'b0};
          end
          dv_cnt <= dv_cnt - 5'd1;
        end
        S_COMPUTE: begin
          w_idx <= '0;
          if (halt_flag) begin
            p_ov_v   <= 1'b0;
            p_ov     <= '0;
            p_status <= halt_cause;
          end else begin
            p_ov_v   <= c_ov_v;
            p_ov     <= c_ov;
            p_status <= c_fin;
            sp       <= c_ns13;
            bp       <= c_nb;
            fd       <= c_nfd;
            pc       <= c_npc[PC_W-1:0];
            w_num    <= c_wn;
            for (int i = 0; i < 3; i++) begin
              wa[i] <= c_wa[i];
              wd[i] <= c_wd[i];
            end
            if (c_fin != ST_OK) begin
              halt_flag  <= 1'b1;
              halt_cause <= c_fin;
            end
          end
        end
        S_WRITE: w_idx <= w_idx + 2'd1;
        S_FIN: begin
          if (!res_valid || res_ready) begin
            res_valid <= 1'b1;
            next_pc   <= pc;
            out_valid <= p_ov_v;
            out_value <= p_ov;
            halted    <= halt_flag;
            status    <= p_status;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== design/pl0sm_checker.sv =====
// Port-level checks for the PL/0 stack machine step block, bound to the top.
// Depends on pl0sm_pkg and pl0_stack_machine_step.
module pl0sm_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic [3:0]                          opcode,
  input logic [pl0sm_pkg::LVL_W-1:0]         level,
  input logic signed [pl0sm_pkg::WORD_W-1:0] modifier,
  input logic signed [pl0sm_pkg::WORD_W-1:0] read_value,
  input logic                                res_valid,
  input logic                                res_ready,
  input logic [pl0sm_pkg::PC_W-1:0]          next_pc,
  input logic                                out_valid,
  input logic signed [pl0sm_pkg::WORD_W-1:0] out_value,
  input logic                                halted,
  input logic [3:0]                          status,
  input logic                                cfg_we,
  input logic [pl0sm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input logic [pl0sm_pkg::PTR_W-1:0]         cfg_data
);
  import pl0sm_pkg::*;

  // remember the first halting result
  logic             seen_halt;
  logic [3:0]       last_status;
  logic [PC_W-1:0]  last_pc;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_halt <= 1'b0;
    end else if (res_valid && res_ready && halted && !seen_halt) begin
      seen_halt   <= 1'b1;
      last_status <= status;
      last_pc     <= next_pc;
    end
  end

  // one instruction at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an instruction is in flight");

  // once halted, the machine is frozen
  a_frozen: assert property (@(posedge clk) disable iff (rst)
    res_valid && seen_halt |->
      halted && !out_valid && status == last_status && next_pc == last_pc)
    else $error("state changed after halt");

  // no output value without its flag
  a_out_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !out_valid |-> out_value == '0)
    else $error("out_value nonzero without out_valid");

  // stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=>
      res_valid && $stable(out_value) && $stable(next_pc) && $stable(status))
    else $error("result changed while stalled");

endmodule

bind pl0_stack_machine_step pl0sm_checker u_pl0sm_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for pl0_stack_machine_step: a shadow stack machine
// predicts every result. Depends on pl0sm_pkg and the design sources.
module testbench;
  import pl0sm_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_SHOWN   = 10;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [4:0]  level;
    logic [31:0] modifier;
    logic [31:0] read_value;
  } instr_t;

  typedef struct packed {
    logic [9:0]  pc;
    logic        ovalid;
    logic [31:0] oval;
    logic        hlt;
    logic [3:0]  st;
  } vm_result_t;

  logic clk, rst;
  logic in_valid, in_ready, res_valid, res_ready;
  logic [3:0] opcode;
  logic [LVL_W-1:0] level;
  logic signed [WORD_W-1:0] modifier, read_value;
  logic [PC_W-1:0] next_pc;
  logic out_valid, halted;
  logic signed [WORD_W-1:0] out_value;
  logic [3:0] status;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PTR_W-1:0] cfg_data;

  // shadow machine state and configuration
  word_t       vm_stack [STACK_DEPTH];
  logic [12:0] vm_sp, vm_bp;
  logic [9:0]  vm_pc;
  logic [5:0]  vm_fd;
  bit          vm_halt;
  logic [3:0]  vm_cause;
  bit          vm_ce;
  logic [12:0] vm_lim;
  logic [5:0]  vm_dlim;

  vm_result_t pending_results[$];
  int errors, cycles, n_items, n_outputs, n_halt_items;
  bit no_idle, drive_hi, rdy_hi;

  pl0_stack_machine_step u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .level(level), .modifier(modifier), .read_value(read_value),
    .res_valid(res_valid), .res_ready(res_ready),
    .next_pc(next_pc), .out_valid(out_valid), .out_value(out_value),
    .halted(halted), .status(status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 0;
  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // shadow machine helpers
  function automatic longint s32(input word_t w);
    return longint'($signed(w));
  endfunction

  function automatic word_t rd(input longint a);
    return vm_stack[a[11:0]];
  endfunction

  function automatic logic [3:0] sp_range(input longint c);
    if (!vm_ce) return ST_OK;
    if (c < 0) return ST_UNDER;
    if (c >= longint'(vm_lim) || c >= STACK_DEPTH) return ST_OVER;
    return ST_OK;
  endfunction

  function automatic longint walk_links(input logic [4:0] lvl, input longint b);
    longint fb;
    fb = b;
    for (int i = 0; i < lvl; i++) fb = s32(rd(fb + 1));
    return fb;
  endfunction

  // one instruction; with commit clear only the outcome is computed
  function automatic bit vm_step(input instr_t it, input bit commit,
                                 output vm_result_t r);
    longint s, b, npc, ns, nb, c, base, idx, m, x, y;
    logic [5:0] nfd;
    logic [3:0] st;
    bit ovd;
    word_t ov, res;
    longint wa[3];
    word_t wd[3];
    int nw;
    logic [12:0] nsp;
    if (vm_halt) begin
      r = '{vm_pc, 1'b0, 32'd0, 1'b1, vm_cause};
      return 1;
    end
    s = longint'(vm_sp); b = longint'(vm_bp);
    npc = longint'(vm_pc) + 1; ns = s; nb = b; nfd = vm_fd;
    st = ST_OK; ovd = 0; ov = '0; nw = 0; res = '0;
    m = s32(it.modifier);
    case (it.opcode)
      OP_DEC, OP_INC: begin
        c = (it.opcode == OP_DEC) ? s - m : s + m;
        st = sp_range(c);
        if (st == ST_OK) ns = c;
      end
      OP_LIT, OP_LOD: begin
        c = s + 1;
        st = sp_range(c);
        if (st == ST_OK) begin
          wa[0] = c;
          wd[0] = (it.opcode == OP_LIT) ? it.modifier : rd(walk_links(it.level, b) + m);
          nw = 1; ns = c;
        end
      end
      OP_OPR: begin
        if (m == OPR_RET) begin
          if (vm_fd == 0) begin
            ovd = 1; ov = vm_stack[1]; st = ST_MAINRET;
          end else begin
            st = sp_range(b - 1);
            if (st == ST_OK) begin
              ns = b - 1; npc = s32(rd(b + 3)); nb = s32(rd(b + 2)); nfd = vm_fd - 1;
            end
          end
        end else if (m == OPR_NEG) begin
          wa[0] = s; wd[0] = 32'd0 - rd(s); nw = 1;
        end else if (m == OPR_ODD) begin
          wa[0] = s; wd[0] = rd(s) & 32'd1; nw = 1;
        end else if (m >= OPR_ADD && m <= OPR_GE) begin
          c = s - 1;
          st = sp_range(c);
          if (st == ST_OK) begin
            x = s32(rd(c)); y = s32(rd(s));
            case (m)
              OPR_ADD: res = x + y;
              OPR_SUB: res = x - y;
              OPR_MUL: res = x * y;
              OPR_DIV: if (y == 0) st = ST_DIVZ; else res = x / y;
              OPR_MOD: if (y == 0) st = ST_DIVZ; else res = x % y;
              OPR_EQ:  res = {31'd0, x == y};
              OPR_NE:  res = {31'd0, x != y};
              OPR_LT:  res = {31'd0, x < y};
              OPR_LE:  res = {31'd0, x <= y};
              OPR_GT:  res = {31'd0, x > y};
              default: res = {31'd0, x >= y};
            endcase
            if (st == ST_OK) begin
              wa[0] = c; wd[0] = res; nw = 1; ns = c;
            end
          end
        end else begin
          st = ST_BADOPR;
        end
      end
      OP_STO: begin
        c = s - 1;
        st = sp_range(c);
        if (st == ST_OK) begin
          wa[0] = walk_links(it.level, b) + m; wd[0] = rd(s); nw = 1; ns = c;
        end
      end
      OP_CAL: begin
        if (vm_fd >= vm_dlim || vm_fd >= MAX_CALL_DEPTH) st = ST_DEPTH;
        else begin
          st = sp_range(s + 4);
          if (st == ST_OK) begin
            base = walk_links(it.level, b);
            wa[0] = s + 2; wd[0] = base[31:0];
            wa[1] = s + 3; wd[1] = b[31:0];
            wa[2] = s + 4; wd[2] = npc[31:0];
            nw = 3; nb = s + 1; npc = m; nfd = vm_fd + 1;
          end
        end
      end
      OP_JMP: npc = m;
      OP_JPC: begin
        c = s - 1;
        st = sp_range(c);
        if (st == ST_OK) begin
          if (rd(s) == 0) npc = m;
          ns = c;
        end
      end
      OP_SIO: begin
        if (m == SIO_IN) begin
          c = s + 1;
          st = sp_range(c);
          if (st == ST_OK) begin
            wa[0] = c; wd[0] = it.read_value; nw = 1; ns = c;
          end
        end else if (m == SIO_OUT0 || m == SIO_OUT1) begin
          c = s - 1;
          st = sp_range(c);
          if (st == ST_OK) begin
            ovd = 1; ov = rd(s); ns = c;
          end
        end else begin
          st = ST_BADIO;
        end
      end
      OP_LDA: begin
        st = sp_range(s);
        if (st == ST_OK) begin
          base = walk_links(it.level, b) + m;
          idx = s32(rd(s));
          if (idx < 0 || idx >= s32(rd(base))) st = ST_BOUNDS;
          else begin
            wa[0] = s; wd[0] = rd(base + idx + 1); nw = 1;
          end
        end
      end
      OP_STA: begin
        c = s - 2;
        st = sp_range(c);
        if (st == ST_OK) begin
          base = walk_links(it.level, b) + m;
          idx = s32(rd(s - 1));
          if (idx < 0 || idx >= s32(rd(base))) st = ST_BOUNDS;
          else begin
            wa[0] = base + idx + 1; wd[0] = rd(s); nw = 1; ns = c;
          end
        end
      end
      default: st = ST_BADOPR;
    endcase
    // a failing instruction keeps only the pc increment
    if (st != ST_OK && st != ST_MAINRET) begin
      ovd = 0; ov = '0; nw = 0;
      npc = longint'(vm_pc) + 1; ns = s; nb = b; nfd = vm_fd;
    end
    if (st == ST_MAINRET) npc = longint'(vm_pc) + 1;
    nsp = ns[12:0];
    if (st == ST_OK && vm_ce) begin
      if (nsp >= vm_lim || nsp >= STACK_DEPTH) st = ST_OVER;
      else if (npc < 0 || npc >= CODE_DEPTH) st = ST_PCRANGE;
    end
    r = '{npc[9:0], ovd, ovd ? ov : 32'd0, st != ST_OK, st};
    if (commit) begin
      for (int i = 0; i < nw; i++) vm_stack[wa[i][11:0]] = wd[i];
      vm_sp = nsp; vm_bp = nb[12:0]; vm_fd = nfd; vm_pc = npc[9:0];
      if (st != ST_OK) begin
        vm_halt = 1; vm_cause = st;
      end
    end
    return st != ST_OK;
  endfunction

  function automatic instr_t mk(input logic [3:0] op, input logic [4:0] lvl,
                                input logic [31:0] m, input logic [31:0] rv);
    return '{op, lvl, m, rv};
  endfunction

  // random instruction biased toward programs that keep running
  function automatic instr_t random_program_instr();
    logic [3:0] op;
    logic [4:0] lvl;
    logic [31:0] m;
    op = 4'($urandom_range(0, 11));
    lvl = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 2));
    case (op)
      OP_LIT:         m = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 9);
      OP_OPR:         m = $urandom_range(0, 13);
      OP_SIO:         m = $urandom_range(0, 2);
      OP_INC:         m = $urandom_range(0, 6);
      OP_DEC:         m = $urandom_range(0, 3);
      OP_JMP, OP_JPC, OP_CAL:
        m = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 40);
      default:        m = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 8);
    endcase
    return mk(op, lvl, m, $urandom);
  endfunction

  function automatic instr_t running_instr();
    instr_t it;
    vm_result_t r;
    for (int i = 0; i < 40; i++) begin
      it = random_program_instr();
      if (!vm_step(it, 0, r)) return it;
    end
    return mk(OP_JMP, 5'($urandom), $urandom_range(0, 1023), $urandom);
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 13);
  endfunction

  // one input transfer; the expectation is queued at acceptance
  task automatic send_instr(input instr_t it);
    int gap;
    vm_result_t r;
    gap = draw_gap();
    if (gap > 0) begin
      if (drive_hi) begin
        in_valid <= 1'b0;
        drive_hi = 0;
      end
      repeat (gap) @(posedge clk);
    end
    opcode <= it.opcode; level <= it.level;
    modifier <= it.modifier; read_value <= it.read_value;
    if (!drive_hi) begin
      in_valid <= 1'b1;
      drive_hi = 1;
    end
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    void'(vm_step(it, 1, r));
    if (r.hlt) n_halt_items++;
    pending_results.push_back(r);
    n_items++;
  endtask

  // directed items that would stop the machine are swapped for running ones
  task automatic send_running(input instr_t it);
    vm_result_t r;
    if (vm_step(it, 0, r)) it = running_instr();
    send_instr(it);
  endtask

  task automatic drain();
    if (drive_hi) begin
      in_valid <= 1'b0;
      drive_hi = 0;
    end
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_cfg(input bit ce, input int lim, input int dl);
    cfg_we <= 1'b1; cfg_index <= CFG_CHECK_ENABLE; cfg_data <= PTR_W'(ce);
    @(posedge clk);
    cfg_index <= CFG_STACK_LIMIT; cfg_data <= PTR_W'(lim);
    @(posedge clk);
    cfg_index <= CFG_CALL_DEPTH_LIMIT; cfg_data <= PTR_W'(dl);
    @(posedge clk);
    cfg_we <= 1'b0;
    vm_ce = ce; vm_lim = 13'(lim); vm_dlim = 6'(dl);
  endtask

  // tests
  task automatic test_tight_limits();
    program_cfg(1, 4, 1);
    repeat (40) send_instr(running_instr());
    drain();
  endtask

  task automatic test_directed();
    program_cfg(1, 4096, 32);
    send_running(mk(OP_LIT, 0, 32'h7fffffff, 0));
    send_running(mk(OP_LIT, 0, 32'h80000000, 0));
    send_running(mk(OP_LIT, 0, 32'hffffffff, 0));
    send_running(mk(OP_OPR, 0, OPR_DIV, 0));   // minimum divided by -1
    send_running(mk(OP_LIT, 0, 32'h80000000, 0));
    send_running(mk(OP_LIT, 0, 32'hffffffff, 0));
    send_running(mk(OP_OPR, 0, OPR_MOD, 0));
    send_running(mk(OP_OPR, 0, OPR_NEG, 0));
    send_running(mk(OP_OPR, 0, OPR_ODD, 0));
    send_running(mk(OP_SIO, 0, SIO_IN, 32'h7fffffff));
    send_running(mk(OP_SIO, 0, SIO_IN, 32'h80000000));
    send_running(mk(OP_OPR, 0, OPR_MUL, 0));
    send_running(mk(OP_LIT, 0, 3, 0));
    send_running(mk(OP_OPR, 0, OPR_LT, 0));
    send_running(mk(OP_SIO, 0, SIO_OUT0, 0));
    send_running(mk(OP_INC, 0, 5, 0));
    send_running(mk(OP_LOD, 31, 0, 0));
    send_running(mk(OP_STO, 0, 2, 0));
    send_running(mk(OP_DEC, 0, 2, 0));
    send_running(mk(OP_JPC, 0, 12, 0));
    send_running(mk(OP_CAL, 1, 20, 0));
    send_running(mk(OP_SIO, 0, SIO_IN, 1));
    send_running(mk(OP_SIO, 0, SIO_OUT1, 0));
    send_running(mk(OP_OPR, 0, OPR_RET, 0));
    send_running(mk(OP_JMP, 0, 1023, 0));
  endtask

  task automatic test_random_checked();
    for (int i = 0; i < 200; i++) begin
      no_idle = (i >= 60 && i < 100);
      if (i == 130) drain();     // sender holds off until all results are back
      send_instr(running_instr());
    end
    no_idle = 0;
    drain();
  endtask

  task automatic test_unchecked();
    program_cfg(0, $urandom_range(4, 4096), $urandom_range(1, 32));
    repeat (200) send_instr(running_instr());
    drain();
    program_cfg(0, 4096, 32);
    repeat (60) send_instr(running_instr());
    drain();
  endtask

  // unconstrained items until the machine stops, then check it stays frozen
  task automatic test_halt();
    int guard;
    program_cfg($urandom_range(0, 1), $urandom_range(4, 4096), $urandom_range(1, 32));
    guard = 0;
    while (!vm_halt && guard < 2000) begin
      send_instr(mk(4'($urandom), 5'($urandom), $urandom, $urandom));
      guard++;
    end
    repeat (6) send_instr(mk(4'($urandom), 5'($urandom), $urandom, $urandom));
  endtask

  // result receiver with random stalls
  initial begin
    int w;
    res_ready = 0;
    rdy_hi = 0;
    wait (!rst);
    @(posedge clk);
    forever begin
      w = draw_gap();
      if (w > 0) begin
        if (rdy_hi) begin
          res_ready <= 1'b0;
          rdy_hi = 0;
        end
        repeat (w) @(posedge clk);
      end
      if (!rdy_hi) begin
        res_ready <= 1'b1;
        rdy_hi = 1;
      end
      @(posedge clk);
      while (!res_valid) @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    vm_result_t e;
    if (!rst && res_valid && res_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN) $display("unexpected result: pc %0d status %0d", next_pc, status);
      end else begin
        e = pending_results.pop_front();
        if (next_pc !== e.pc || out_valid !== e.ovalid || out_value !== e.oval ||
            halted !== e.hlt || status !== e.st) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("mismatch: exp pc %0d ov %0b val %0d h %0b st %0d | got pc %0d ov %0b val %0d h %0b st %0d",
                     e.pc, e.ovalid, $signed(e.oval), e.hlt, e.st,
                     next_pc, out_valid, out_value, halted, status);
        end else if (e.ovalid) begin
          n_outputs++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    rst = 1; in_valid = 0; opcode = '0; level = '0; modifier = '0; read_value = '0;
    cfg_we = 0; cfg_index = '0; cfg_data = '0;
    errors = 0; cycles = 0; n_items = 0; n_outputs = 0; n_halt_items = 0;
    no_idle = 0; drive_hi = 0;
    for (int i = 0; i < STACK_DEPTH; i++) vm_stack[i] = '0;
    vm_sp = 0; vm_bp = 1; vm_pc = 0; vm_fd = 0; vm_halt = 0; vm_cause = ST_OK;
    vm_ce = 1; vm_lim = 13'd4096; vm_dlim = 6'd32;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_tight_limits();
    test_directed();
    test_random_checked();
    test_unchecked();
    test_halt();

    drain();
    repeat (100) @(posedge clk);
    if (pending_results.size() != 0) errors++;
    $display("%0d instructions sent, %0d carried output values, %0d answered halted (cause %0d)",
             n_items, n_outputs, n_halt_items, vm_cause);
    $display("configs covered: tight limits, defaults, checks off; %0d failures", errors);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/pl0sm_pkg.sv
design/pl0sm_ram.sv
design/pl0_stack_machine_step.sv
design/pl0sm_checker.sv
tb/testbench.sv
